// ----- sv/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and fixed field widths for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CAP_W   = 5;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried on the slave-side tuser.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Recency update request from the sequencer.
  typedef struct packed {
    logic en;      // apply an update this cycle
    logic insert;  // new entry: all valid entries age, target becomes valid
  } rank_upd_t;

  // Per-entry status returned for the entry under scan.
  typedef struct packed {
    logic valid;   // entry holds a key
    logic is_lru;  // entry is the least recently used one
  } scan_info_t;

endpackage

// ----- sv/lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request scans every entry in turn, one entry a cycle through the single
// key comparator, then writes its result to the master-side output register.
// No new request is taken until that result has been written; a result left
// waiting in the output register holds off the next request.
// Reset: asynchronous, active low; all entries invalid, occupancy zero,
// capacity 16. Key, value and length storage is not cleared.
module lru_key_value_cache_unit import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: capacity register.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i,
  // Request stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [79:0]      s_axis_tdata,   // key [31:0], value [63:32], length [79:64]
  input  logic [0:0]       s_axis_tuser,   // cmd [0]
  // Result stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // read_value [31:0], read_length [47:32]
  output logic [1:0]       m_axis_tuser    // hit [0], evicted [1]
);

  // Stored key and data are narrowed to the parameters; the stream fields
  // only ever carry 32 bits of each.
  localparam int unsigned KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned DW    = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;
  localparam int unsigned MW    = LEN_W + DW + KW;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CAP_W-1:0] cap_q;

  // Request held for the whole operation.
  logic               cmd_q;
  logic [KW-1:0]      key_q;
  logic [DW-1:0]      val_q;
  logic [LEN_W-1:0]   len_q;

  // Scan issue side.
  logic [IDX_W-1:0]   iss_idx_q;
  logic               iss_done_q;
  logic               iss_en;

  // Compare stage: registered memory word and entry status.
  logic [MW-1:0]      mem [ENTRIES];
  logic [MW-1:0]      rdata_q;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  scan_info_t         scan_info;
  scan_info_t         cmp_info_q;
  logic [KW-1:0]      rd_key;
  logic               key_match;

  // Scan results.
  logic               found_q;
  logic [IDX_W-1:0]   found_idx_q;
  logic [DW-1:0]      found_val_q;
  logic [LEN_W-1:0]   found_len_q;
  logic               free_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [IDX_W-1:0]   lru_idx_q;

  // Apply step.
  logic               fire;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  rank_upd_t          upd;
  logic [IDX_W-1:0]   upd_idx;
  logic [OCC_W-1:0]   occ;
  logic [CW-1:0]      eff_cap;
  logic               room;
  logic               res_hit, res_evicted;
  logic [VALUE_W-1:0] res_val;
  logic [LEN_W-1:0]   res_len;

  // Output register.
  logic               out_vld_q;
  logic               out_hit_q, out_evicted_q;
  logic [VALUE_W-1:0] out_val_q;
  logic [LEN_W-1:0]   out_len_q;

  // --------------------------------------------------------------------------
  // Configuration. Writes must arrive only while the block is idle; the block
  // itself does not enforce this, and the register is always ready.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // A capacity of zero behaves as one, and one above the entry count as the
  // entry count.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_q) > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  assign room = CW'(occ) < eff_cap;

  // --------------------------------------------------------------------------
  // Sequencer. A request is taken only in the idle state; the scan reads one
  // entry a cycle, and the apply step writes the result once the output
  // register can take it.
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign iss_en        = (state_q == S_SCAN) && !iss_done_q;
  assign fire          = (state_q == S_APPLY) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      iss_idx_q  <= '0;
      iss_done_q <= 1'b0;
      cmp_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= iss_en;
      if (s_axis_tvalid && s_axis_tready) begin
        iss_idx_q  <= '0;
        iss_done_q <= 1'b0;
      end else if (iss_en) begin
        if (iss_idx_q == LAST_IDX) begin
          iss_done_q <= 1'b1;
        end else begin
          iss_idx_q <= iss_idx_q + 1'b1;
        end
      end
    end
  end

  // Request capture; the payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser[0];
      key_q <= s_axis_tdata[KW-1:0];
      val_q <= s_axis_tdata[KEY_W +: DW];
      len_q <= s_axis_tdata[KEY_W+VALUE_W +: LEN_W];
    end
  end

  // --------------------------------------------------------------------------
  // Entry storage: one word per entry holding {length, data, key}, one read
  // port for the scan and one write port for the apply step.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {len_q, val_q, key_q};
    end
    if (iss_en) begin
      rdata_q <= mem[iss_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_en) begin
      cmp_idx_q  <= iss_idx_q;
      cmp_info_q <= scan_info;
    end
  end

  // --------------------------------------------------------------------------
  // Shared compare unit. The first matching valid entry is the hit, the
  // lowest invalid entry is the free slot, and the entry whose rank is one
  // below the occupancy is the eviction victim.
  // --------------------------------------------------------------------------
  assign rd_key    = rdata_q[KW-1:0];
  assign key_match = cmp_info_q.valid && (rd_key == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmp_vld_q) begin
      if (key_match && !found_q) begin
        found_q <= 1'b1;
      end
      if (!cmp_info_q.valid && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_vld_q) begin
      if (key_match && !found_q) begin
        found_idx_q <= cmp_idx_q;
        found_val_q <= rdata_q[KW +: DW];
        found_len_q <= rdata_q[KW+DW +: LEN_W];
      end
      if (!cmp_info_q.valid && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (cmp_info_q.is_lru) begin
        lru_idx_q <= cmp_idx_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Apply step. A get hit and a put hit refresh the matching entry, a put
  // miss with room fills the free slot, and any other put miss replaces the
  // least recent entry. When the capacity has been lowered below the
  // occupancy, no entry is dropped; a new key only replaces the oldest one.
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = found_idx_q;
    upd.en      = 1'b0;
    upd.insert  = 1'b0;
    upd_idx     = found_idx_q;
    res_hit     = found_q;
    res_evicted = 1'b0;
    res_val     = '0;
    res_len     = '0;
    if (cmd_q == CMD_GET) begin
      if (found_q) begin
        upd.en  = fire;
        res_val = VALUE_W'(found_val_q);
        res_len = found_len_q;
      end
    end else if (found_q) begin
      mem_we = fire;
      upd.en = fire;
    end else if (room && free_q) begin
      mem_we     = fire;
      mem_waddr  = free_idx_q;
      upd.en     = fire;
      upd.insert = 1'b1;
      upd_idx    = free_idx_q;
    end else if (occ != '0) begin
      mem_we      = fire;
      mem_waddr   = lru_idx_q;
      upd.en      = fire;
      upd_idx     = lru_idx_q;
      res_evicted = 1'b1;
    end
  end

  lkvc_recency #(
    .ENTRIES (ENTRIES)
  ) u_recency (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_idx_i  (iss_idx_q),
    .scan_info_o (scan_info),
    .upd_i       (upd),
    .upd_idx_i   (upd_idx),
    .occ_o       (occ)
  );

  // --------------------------------------------------------------------------
  // Output register. It holds a finished result until the master-side
  // transfer completes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q     <= res_hit;
      out_evicted_q <= res_evicted;
      out_val_q     <= res_val;
      out_len_q     <= res_len;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_len_q, out_val_q};
  assign m_axis_tuser  = {out_evicted_q, out_hit_q};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_evicted_q |-> !out_hit_q)
    else $error("an eviction was reported together with a hit");

  a_data_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ((out_val_q != '0) || (out_len_q != '0)) |-> out_hit_q)
    else $error("read data returned without a hit");

  a_full_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) && ($past(state_q) == S_SCAN)
      |-> $past(cmp_vld_q) && ($past(cmp_idx_q) == LAST_IDX))
    else $error("apply step entered before the last entry was compared");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !fire)
    else $error("result written while the scan was still running");

endmodule

// ----- sv/lkvc_recency.sv -----
// ----------------------------------------------------------------------------
// lkvc_recency
// Valid bits, recency ranks and occupancy of the cache entries.
// ----------------------------------------------------------------------------
module lkvc_recency import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(ENTRIES)-1:0]         scan_idx_i,
  output scan_info_t                         scan_info_o,
  input  rank_upd_t                          upd_i,
  input  logic [$clog2(ENTRIES)-1:0]         upd_idx_i,
  output logic [$clog2(ENTRIES+1)-1:0]       occ_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned RK_W  = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid_q;
  logic [RK_W-1:0]    rank_q [ENTRIES];
  logic [OCC_W-1:0]   occ_q;
  logic [RK_W:0]      thr;

  // Entries more recent than the threshold age by one. An insert ages every
  // valid entry.
  assign thr = upd_i.insert ? (RK_W+1)'(ENTRIES) : (RK_W+1)'(rank_q[upd_idx_i]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (upd_i.en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == upd_idx_i) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && ((RK_W+1)'(rank_q[i]) < thr)) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
      if (upd_i.insert) begin
        valid_q[upd_idx_i] <= 1'b1;
        occ_q              <= occ_q + 1'b1;
      end
    end
  end

  // Valid ranks are always 0 .. occupancy-1, so the oldest entry holds the
  // rank one below the occupancy.
  assign scan_info_o.valid  = valid_q[scan_idx_i];
  assign scan_info_o.is_lru = valid_q[scan_idx_i]
                              && (OCC_W'(rank_q[scan_idx_i]) == (occ_q - 1'b1));
  assign occ_o = occ_q;

  a_occ_counts_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q)
    else $error("occupancy does not match the number of valid entries");

  a_insert_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.en && upd_i.insert |-> !valid_q[upd_idx_i])
    else $error("insert targets an entry that is already valid");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(ENTRIES))
    else $error("occupancy exceeds the number of entries");

endmodule
